// ===== rtl/lau_pkg.sv =====
// shared types and constants of the light attenuation unit
`default_nettype none
package lau_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KIND    = 3'd0,
		REG_POS     = 3'd1,
		REG_DIR     = 3'd2,
		REG_CONST   = 3'd3,
		REG_LIN     = 3'd4,
		REG_QUAD    = 3'd5,
		REG_COS_IN  = 3'd6,
		REG_COS_OUT = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [23:0] ONE_Q16  = 24'd65536;
	localparam logic [23:0] MAX_OUT  = 24'hFFFFFF;
	localparam logic [48:0] ONE_Q48  = 49'h1_0000_0000_0000;
	localparam logic [39:0] F_CLAMP  = 40'h80_0000_0000;
	localparam logic [16:0] COS_SAT  = 17'h10000;

	// sideband through the square root pipe
	typedef struct packed {
		logic        near;
		logic [43:0] s;
		logic [43:0] dot;
	} sqrt_side_t;

	// sideband through the distance factor divider
	typedef struct packed {
		logic dz;
		logic dbig;
	} fdiv_side_t;

	// sideband through the cosine divider
	typedef struct packed {
		logic near;
	} cdiv_side_t;

	// sideband through the ramp divider
	typedef struct packed {
		logic        near;
		logic        use_div;
		logic [15:0] rconst;
		logic [39:0] fc;
	} rdiv_side_t;

endpackage
`default_nettype wire

// ===== rtl/lau_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module lau_sqrt #(
	parameter int XW = 56,
	parameter int SW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [XW-1:0]     x,
	input  wire logic [SW-1:0]     side_in,
	output logic                   out_valid,
	output logic [XW/2-1:0]        root,
	output logic [SW-1:0]          side_out
);
	localparam int RW = XW / 2;

	logic          vld_q  [RW];
	logic [XW-1:0] x_q    [RW];
	logic [RW-1:0] rt_q   [RW];
	logic [RW+1:0] rem_q  [RW];
	logic [SW-1:0] side_q [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic          pv;
		logic [XW-1:0] px;
		logic [RW-1:0] pt;
		logic [RW+1:0] pr;
		logic [SW-1:0] ps;
		logic [RW+3:0] r;
		logic [RW+3:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign px = x;
			assign pt = '0;
			assign pr = '0;
			assign ps = side_in;
		end else begin : g_next
			assign pv = vld_q[k-1];
			assign px = x_q[k-1];
			assign pt = rt_q[k-1];
			assign pr = rem_q[k-1];
			assign ps = side_q[k-1];
		end

		// bring down two radicand bits, try root bit one
		assign r     = {pr, px[XW-1:XW-2]};
		assign trial = (RW+4)'({pt, 2'b01});
		assign ge    = r >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k]    <= px << 2;
				rt_q[k]   <= {pt[RW-2:0], ge};
				rem_q[k]  <= ge ? (RW+2)'(r - trial) : (RW+2)'(r);
				side_q[k] <= ps;
			end
		end
	end

	assign out_valid = vld_q[RW-1];
	assign root      = rt_q[RW-1];
	assign side_out  = side_q[RW-1];

endmodule
`default_nettype wire

// ===== rtl/lau_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lau_div #(
	parameter int NW = 49,
	parameter int DW = 49,
	parameter int SW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] dvs,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [NW-1:0]      quo,
	output logic [SW-1:0]      side_out
);
	logic          vld_q  [NW];
	logic [NW-1:0] nq_q   [NW];
	logic [DW-1:0] dvs_q  [NW];
	logic [DW-1:0] rem_q  [NW];
	logic [SW-1:0] side_q [NW];

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic          pv;
		logic [NW-1:0] pn;
		logic [DW-1:0] pd;
		logic [DW-1:0] pr;
		logic [SW-1:0] ps;
		logic [DW:0]   r;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign pn = num;
			assign pd = dvs;
			assign pr = '0;
			assign ps = side_in;
		end else begin : g_next
			assign pv = vld_q[k-1];
			assign pn = nq_q[k-1];
			assign pd = dvs_q[k-1];
			assign pr = rem_q[k-1];
			assign ps = side_q[k-1];
		end

		// numerator bits leave at the top, quotient bits enter at the bottom
		assign r  = {pr, pn[NW-1]};
		assign ge = r >= {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[k]   <= {pn[NW-2:0], ge};
				rem_q[k]  <= ge ? DW'(r - {1'b0, pd}) : r[DW-1:0];
				dvs_q[k]  <= pd;
				side_q[k] <= ps;
			end
		end
	end

	assign out_valid = vld_q[NW-1];
	assign quo       = nq_q[NW-1];
	assign side_out  = side_q[NW-1];

endmodule
`default_nettype wire

// ===== rtl/light_attenuation_unit_core.sv =====
// top level of the light attenuation unit
//
// Takes one fragment position per clock and returns one Q8.16 attenuation
// per fragment, in order. The steps are: difference, products and sums; the
// root-per-bit square root; the denominator; the distance and cosine dividers
// running side by side; the cone ramp setup; the ramp divider; the final
// product; and the output register. Throughput is one item per clock; the whole
// pipe holds while a result sits in the output register and is not taken.
// Configuration writes are always accepted and take effect at once; the
// registers are read at several stages, so write only while the pipe is empty.
`default_nettype none
module light_attenuation_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // frag_x[20:0], frag_y[41:21], frag_z[62:42]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // attenuation[23:0]
	output logic [0:0]       m_tuser,   // saturated[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [62:0] cfg_data
);
	// configuration registers
	logic        kind_q;
	logic [62:0] pos_q;
	logic [62:0] dir_q;
	logic [23:0] kc_q;
	logic [23:0] kl_q;
	logic [23:0] kq_q;
	logic [15:0] cin_q;
	logic [15:0] cout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			pos_q  <= '0;
			dir_q  <= '0;
			kc_q   <= lau_pkg::ONE_Q16;
			kl_q   <= '0;
			kq_q   <= '0;
			cin_q  <= lau_pkg::ONE_Q15;
			cout_q <= '0;
		end else if (cfg_valid) begin
			unique case (lau_pkg::cfg_reg_t'(cfg_index))
				lau_pkg::REG_KIND:    kind_q <= cfg_data[0];
				lau_pkg::REG_POS:     pos_q  <= cfg_data;
				lau_pkg::REG_DIR:     dir_q  <= cfg_data;
				lau_pkg::REG_CONST:   kc_q   <= cfg_data[23:0];
				lau_pkg::REG_LIN:     kl_q   <= cfg_data[23:0];
				lau_pkg::REG_QUAD:    kq_q   <= cfg_data[23:0];
				lau_pkg::REG_COS_IN:  cin_q  <= cfg_data[15:0];
				lau_pkg::REG_COS_OUT: cout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// global pipeline advance
	logic adv;
	logic out_vld_q;
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	// stage 1: light-to-fragment vector
	logic               v_s1;
	logic signed [21:0] vec_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				vec_s1[k] <= $signed({s_tdata[21*k+20], s_tdata[21*k +: 21]})
				           - $signed({pos_q[21*k+20], pos_q[21*k +: 21]});
			end
		end
	end

	// stage 2: squares and direction products
	logic               v_s2;
	logic        [41:0] sq_s2 [3];
	logic signed [43:0] dp_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= 42'(vec_s1[k] * vec_s1[k]);
				dp_s2[k] <= 44'(vec_s1[k] * $signed(dir_q[21*k +: 21]));
			end
		end
	end

	// stage 3: squared length and dot product
	logic        v_s3;
	logic [43:0] s_s3;
	logic [43:0] dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3   <= 44'(sq_s2[0]) + 44'(sq_s2[1]) + 44'(sq_s2[2]);
			dot_s3 <= 44'(dp_s2[0] + dp_s2[1] + dp_s2[2]);
		end
	end

	// distance as root of squared length in Q.6
	lau_pkg::sqrt_side_t sq_in;
	lau_pkg::sqrt_side_t sq_out;
	logic                sq_vld;
	logic [27:0]         sq_root;

	assign sq_in.near = s_s3 <= 44'd1;
	assign sq_in.s    = s_s3;
	assign sq_in.dot  = dot_s3;

	lau_sqrt #(
		.XW(56),
		.SW($bits(lau_pkg::sqrt_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.x        ({s_s3, 12'd0}),
		.side_in  (sq_in),
		.out_valid(sq_vld),
		.root     (sq_root),
		.side_out (sq_out)
	);

	// stage 4: attenuation products, cosine numerator
	logic        v_s4;
	logic        near_s4;
	logic [45:0] hi_s4;
	logic [45:0] lq_s4;
	logic [51:0] ld_s4;
	logic [27:0] d_s4;
	logic [48:0] cnum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s4 <= sq_out.near;
			hi_s4   <= 46'(kq_q * sq_out.s[43:22]);
			lq_s4   <= 46'(kq_q * sq_out.s[21:0]);
			ld_s4   <= 52'(kl_q * sq_root);
			d_s4    <= sq_root;
			// behind or beside the light gives cosine zero
			cnum_s4 <= (!sq_out.dot[43] && sq_out.dot != '0)
			         ? {4'd0, sq_out.dot[42:0], 2'b00} : '0;
		end
	end

	// stage 5: denominator sum
	logic        v_s5;
	logic        near_s5;
	logic        hbig_s5;
	logic [58:0] den_s5;
	logic [27:0] d_s5;
	logic [48:0] cnum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s5 <= near_s4;
			hbig_s5 <= hi_s4[45:40] != '0;
			den_s5  <= 59'({kc_q, 16'd0}) + 59'(ld_s4) + 59'({hi_s4[39:0], 18'd0})
			         + 59'(lq_s4[45:4]);
			d_s5    <= d_s4;
			cnum_s5 <= cnum_s4;
		end
	end

	// stage 6: divider operands and special denominators
	logic              v_s6;
	lau_pkg::fdiv_side_t fside_s6;
	lau_pkg::cdiv_side_t cside_s6;
	logic [48:0]       dvf_s6;
	logic [27:0]       d_s6;
	logic [48:0]       cnum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fside_s6.dz   <= !hbig_s5 && den_s5 == '0;
			fside_s6.dbig <= hbig_s5 || den_s5 > 59'(lau_pkg::ONE_Q48);
			cside_s6.near <= near_s5;
			dvf_s6        <= den_s5[48:0];
			d_s6          <= d_s5;
			cnum_s6       <= cnum_s5;
		end
	end

	// distance factor and cosine dividers, in lockstep
	logic              fd_vld;
	logic              cd_vld;
	logic [48:0]       fd_quo;
	logic [48:0]       cd_quo;
	lau_pkg::fdiv_side_t fd_side;
	lau_pkg::cdiv_side_t cd_side;

	lau_div #(
		.NW(49),
		.DW(49),
		.SW($bits(lau_pkg::fdiv_side_t))
	) u_fdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (lau_pkg::ONE_Q48),
		.dvs      (dvf_s6),
		.side_in  (fside_s6),
		.out_valid(fd_vld),
		.quo      (fd_quo),
		.side_out (fd_side)
	);

	lau_div #(
		.NW(49),
		.DW(28),
		.SW($bits(lau_pkg::cdiv_side_t))
	) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (cnum_s6),
		.dvs      (d_s6),
		.side_in  (cside_s6),
		.out_valid(cd_vld),
		.quo      (cd_quo),
		.side_out (cd_side)
	);

	// stage 7: clamp distance factor, saturate cosine
	logic        v_s7;
	logic        near_s7;
	logic [39:0] fc_s7;
	logic [16:0] c17_s7;
	logic [48:0] f_full;

	always_comb begin
		if (fd_side.dz) begin
			f_full = lau_pkg::ONE_Q48;
		end else if (fd_side.dbig) begin
			f_full = '0;
		end else begin
			f_full = fd_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= fd_vld && cd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s7 <= cd_side.near;
			// any factor from the clamp up saturates unless the cone is dark or the fragment is near
			fc_s7   <= (f_full[48:39] != '0) ? lau_pkg::F_CLAMP : f_full[39:0];
			c17_s7  <= (cd_quo[48:16] != '0) ? lau_pkg::COS_SAT : {1'b0, cd_quo[15:0]};
		end
	end

	// stage 8: cone ramp setup
	logic        v_s8;
	logic [30:0] rnum_s8;
	logic [15:0] rdvs_s8;
	lau_pkg::rdiv_side_t rside_s8;
	logic [15:0] cos_lo;
	logic [15:0] cos_hi;
	logic        c_le_lo;
	logic        c_ge_hi;

	always_comb begin
		if (cout_q < cin_q) begin
			cos_lo = cout_q;
			cos_hi = cin_q;
		end else begin
			cos_lo = cin_q;
			cos_hi = cout_q;
		end
		c_le_lo = c17_s7 <= {1'b0, cos_lo};
		c_ge_hi = c17_s7 >= {1'b0, cos_hi};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rside_s8.near    <= near_s7;
			rside_s8.fc      <= fc_s7;
			rside_s8.use_div <= kind_q && !c_le_lo && !c_ge_hi;
			rside_s8.rconst  <= (kind_q && c_le_lo) ? 16'd0 : lau_pkg::ONE_Q15;
			rnum_s8          <= {16'(c17_s7[15:0] - cos_lo), 15'd0};
			rdvs_s8          <= cos_hi - cos_lo;
		end
	end

	// ramp divider
	logic        rd_vld;
	logic [30:0] rd_quo;
	lau_pkg::rdiv_side_t rd_side;

	lau_div #(
		.NW(31),
		.DW(16),
		.SW($bits(lau_pkg::rdiv_side_t))
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s8),
		.num      (rnum_s8),
		.dvs      (rdvs_s8),
		.side_in  (rside_s8),
		.out_valid(rd_vld),
		.quo      (rd_quo),
		.side_out (rd_side)
	);

	// stage 9: select ramp
	logic        v_s9;
	logic        near_s9;
	logic [15:0] ramp_s9;
	logic [39:0] fc_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= rd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s9 <= rd_side.near;
			ramp_s9 <= rd_side.use_div ? rd_quo[15:0] : rd_side.rconst;
			fc_s9   <= rd_side.fc;
		end
	end

	// stage 10: factor times ramp
	logic        v_s10;
	logic        near_s10;
	logic [55:0] prod_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s10 <= near_s9;
			prod_s10 <= 56'(fc_s9 * ramp_s9);
		end
	end

	// output register with saturation
	logic [23:0] out_att_q;
	logic        out_sat_q;
	logic        res_sat;

	assign res_sat = prod_s10[55:39] != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (near_s10) begin
				out_att_q <= lau_pkg::ONE_Q16;
				out_sat_q <= 1'b0;
			end else if (res_sat) begin
				out_att_q <= lau_pkg::MAX_OUT;
				out_sat_q <= 1'b1;
			end else begin
				out_att_q <= prod_s10[38:15];
				out_sat_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_att_q;
	assign m_tuser[0] = out_sat_q;

`ifndef NO_ASSERTIONS
	// a saturated item always carries the maximum value
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == lau_pkg::MAX_OUT)
		else $error("saturated item without maximum value");

	// both dividers stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		fd_vld == cd_vld)
		else $error("divider valids out of step");

	// clamped distance factor never exceeds the clamp
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> fc_s7 <= lau_pkg::F_CLAMP)
		else $error("distance factor above clamp");

	// cone ramp stays within one
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> ramp_s9 <= lau_pkg::ONE_Q15)
		else $error("ramp above one");

	// a held output keeps the pipe frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(v_s10) && $stable(prod_s10))
		else $error("pipe moved while output held");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_light_attenuation_unit_core.sv =====
// testbench of the light attenuation unit: directed and random fragments checked against a local predictor
`default_nettype none
module tb_light_attenuation_unit_core;

	// expected attenuation and saturation flag of one fragment
	typedef struct {
		logic [23:0] atten;
		logic        sat;
	} atten_res_t;

	// light registers as the predictor sees them
	logic        kind_r;
	logic [62:0] pos_r;
	logic [62:0] dir_r;
	logic [23:0] c_r, l_r, q_r;
	logic [15:0] cin_r, cout_r;

	function automatic longint sext21(logic [20:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// attenuation of one fragment under the current light registers
	function automatic atten_res_t predict_atten(logic [62:0] frag);
		atten_res_t o;
		longint v;
		longint unsigned s, m, d, den, f, ramp, res, hi, cs, lo, hb;
		longint dot;
		s = 0;
		dot = 0;
		for (int k = 0; k < 3; k++) begin
			v = sext21(frag[21*k +: 21]) - sext21(pos_r[21*k +: 21]);
			m = (v < 0) ? -v : v;
			s += m * m;
			dot += v * sext21(dir_r[21*k +: 21]);
		end
		if (s <= 1) begin
			o.atten = lau_pkg::ONE_Q16;
			o.sat = 1'b0;
			return o;
		end
		d = int_sqrt(s << 12);
		hi = longint'(q_r) * (s >> 22);
		if (hi >= (64'd1 << 40))
			den = 64'd1 << 62;
		else
			den = (longint'(c_r) << 16) + longint'(l_r) * d + (hi << 18)
				+ ((longint'(q_r) * (s & 64'h3FFFFF)) >> 4);
		f = (den == 0) ? (64'd1 << 48) : ((64'd1 << 48) / den);
		if (!kind_r) begin
			ramp = 32768;
		end else begin
			cs = (dot > 0 && d != 0) ? ((longint'(dot) * 4) / d) : 0;
			lo = (cout_r < cin_r) ? cout_r : cin_r;
			hb = (cout_r < cin_r) ? cin_r : cout_r;
			if (cs <= lo) ramp = 0;
			else if (hb == lo) ramp = 32768;
			else begin
				ramp = ((cs - lo) * 32768) / (hb - lo);
				if (ramp > 32768) ramp = 32768;
			end
		end
		res = (f * ramp) >> 15;
		if (res > 64'hFFFFFF) begin
			o.atten = lau_pkg::MAX_OUT;
			o.sat = 1'b1;
		end else begin
			o.atten = res[23:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

	// queue of pending attenuations and the comparison against results
	class atten_board;
		atten_res_t pending[$];
		int errors;
		function void note_fragment(atten_res_t r);
			pending.insert(pending.size(), r);
		endfunction
		function void check_result(logic [23:0] a, logic s);
			atten_res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result atten=%0d sat=%0d", a, s);
				return;
			end
			e = pending.pop_front();
			if (a !== e.atten || s !== e.sat) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected atten=%0d sat=%0d, got atten=%0d sat=%0d",
						e.atten, e.sat, a, s);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [62:0] cfg_data;

	atten_board board;
	int idle_cycles;
	bit hold_sink;
	bit stim_done;

	light_attenuation_unit_core dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// write one light register and mirror it in the predictor
	task automatic write_reg(lau_pkg::cfg_reg_t idx, logic [62:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lau_pkg::REG_KIND:    kind_r = val[0];
			lau_pkg::REG_POS:     pos_r = val;
			lau_pkg::REG_DIR:     dir_r = val;
			lau_pkg::REG_CONST:   c_r = val[23:0];
			lau_pkg::REG_LIN:     l_r = val[23:0];
			lau_pkg::REG_QUAD:    q_r = val[23:0];
			lau_pkg::REG_COS_IN:  cin_r = val[15:0];
			lau_pkg::REG_COS_OUT: cout_r = val[15:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one fragment, after a random gap when gaps is set
	task automatic send_fragment(logic [62:0] frag, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, frag};
		do @(posedge clk); while (!s_tready);
		board.note_fragment(predict_atten(frag));
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	function automatic logic [20:0] rand_coord(int mode);
		case (mode)
			0: return 21'($urandom);
			1: return 21'($urandom_range(0, 4095)) - 21'd2048;
			default: return 21'($urandom_range(0, 65535)) - 21'd32768;
		endcase
	endfunction

	function automatic logic [62:0] rand_frag();
		int mode;
		mode = $urandom_range(0, 2);
		return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
	endfunction

	// unit-ish direction with one dominant axis of random sign
	function automatic logic [62:0] rand_dir();
		logic [62:0] d;
		int ax;
		d = {21'($urandom_range(0, 65535)) - 21'd32768,
			21'($urandom_range(0, 65535)) - 21'd32768,
			21'($urandom_range(0, 65535)) - 21'd32768};
		ax = $urandom_range(0, 2);
		d[21*ax +: 21] = $urandom_range(0, 1) ? 21'd524287 : -21'sd524288;
		return d;
	endfunction

	task automatic random_light();
		logic [15:0] a, b;
		write_reg(lau_pkg::REG_KIND, 63'($urandom_range(0, 1)));
		write_reg(lau_pkg::REG_POS, {rand_coord(1), rand_coord(1), rand_coord(1)});
		write_reg(lau_pkg::REG_DIR,
			$urandom_range(0, 7) == 0 ? 63'({$urandom, $urandom}) : rand_dir());
		write_reg(lau_pkg::REG_CONST,
			63'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072)));
		write_reg(lau_pkg::REG_LIN,
			63'($urandom_range(0, 1) ? $urandom_range(0, 65536) : 24'($urandom)));
		write_reg(lau_pkg::REG_QUAD,
			63'($urandom_range(0, 1) ? $urandom_range(0, 4096) : 24'($urandom)));
		a = 16'($urandom_range(0, 32768));
		b = $urandom_range(0, 4) == 0 ? a : 16'($urandom_range(0, 32768));
		write_reg(lau_pkg::REG_COS_IN, 63'(a));
		write_reg(lau_pkg::REG_COS_OUT, 63'(b));
	endtask

	// stimulus
	initial begin
		board = new();
		kind_r = 0; pos_r = 0; dir_r = 0;
		c_r = 65536; l_r = 0; q_r = 0; cin_r = 32768; cout_r = 0;
		stim_done = 0;
		s_tvalid = 0; s_tdata = 0;
		cfg_valid = 0; cfg_index = lau_pkg::REG_KIND; cfg_data = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: near, extremes
		send_fragment(63'd0, 0);
		send_fragment({21'd0, 21'd0, 21'd1}, 0);
		send_fragment({21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF}, 0);
		send_fragment({21'h100000, 21'h100000, 21'h100000}, 0);
		send_fragment({21'h1FFFFF, 21'h100000, 21'h0FFFFF}, 0);
		drain();
		// zero denominator, then huge quadratic and linear terms
		write_reg(lau_pkg::REG_CONST, 63'd0);
		send_fragment({21'd0, 21'd0, 21'd1024}, 0);
		drain();
		write_reg(lau_pkg::REG_QUAD, 63'hFFFFFF);
		write_reg(lau_pkg::REG_LIN, 63'hFFFFFF);
		send_fragment({21'h100000, 21'h100000, 21'h100000}, 0);
		drain();
		// spot: ahead, behind, beside, equal cosines, reversed cosines
		write_reg(lau_pkg::REG_KIND, 63'd1);
		write_reg(lau_pkg::REG_CONST, 63'd65536);
		write_reg(lau_pkg::REG_LIN, 63'd0);
		write_reg(lau_pkg::REG_QUAD, 63'd0);
		write_reg(lau_pkg::REG_POS, {21'd0, 21'd0, 21'd0});
		write_reg(lau_pkg::REG_DIR, {21'd0, 21'd0, 21'd524287});
		write_reg(lau_pkg::REG_COS_IN, 63'd32768);
		write_reg(lau_pkg::REG_COS_OUT, 63'd16384);
		send_fragment({21'd0, 21'd0, 21'd2048}, 0);
		send_fragment({21'd0, 21'd0, -21'sd2048}, 0);
		send_fragment({21'd0, 21'd2048, 21'd0}, 0);
		send_fragment({21'd0, 21'd1024, 21'd1024}, 0);
		drain();
		write_reg(lau_pkg::REG_COS_IN, 63'd20000);
		write_reg(lau_pkg::REG_COS_OUT, 63'd20000);
		send_fragment({21'd0, 21'd1024, 21'd1024}, 0);
		send_fragment({21'd0, 21'd2048, 21'd100}, 0);
		drain();
		write_reg(lau_pkg::REG_COS_IN, 63'd0);
		write_reg(lau_pkg::REG_COS_OUT, 63'd32768);
		write_reg(lau_pkg::REG_DIR, 63'h7FFFFFFFFFFFFFFF);
		send_fragment({21'd0, 21'd1024, 21'd1024}, 0);
		send_fragment({21'd500, 21'd3, 21'd7}, 0);
		drain();

		// random phases, one with a long receiver hold
		for (int ph = 0; ph < 12; ph++) begin
			random_light();
			if (ph == 3) hold_sink = 1;
			for (int i = 0; i < 160; i++) send_fragment(rand_frag(), 1);
			drain();
		end
		stim_done = 1;
	end

	// receiver: random stalls, and one long hold
	initial begin
		int w;
		m_tready = 0;
		hold_sink = 0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_sink = 0;
			end
			w = $urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 3);
			if (w != 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (stim_done) begin
				if (board.errors == 0 && board.pending.size() == 0)
					$display("ALL CHECKS PASSED");
				else
					$display("CHECKS FAILED");
				$finish;
			end else if (idle_cycles > 5000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
